### hw/rtl/lpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared widths, codes and state encoding for the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // Fixed field widths
  localparam int KEY_W    = 31;
  localparam int SIZE_W   = 11;
  localparam int SLOT_W   = 10;
  localparam int COUNT_W  = 11;
  localparam int KEY_BITC = $clog2(KEY_W);

  // Default table depth and reset value of the size register
  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_CHECK,
    ST_DONE
  } state_t;

endpackage

### hw/rtl/lpht_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/lpht_urem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_urem
// Bit-serial restoring remainder: key modulo table size, one bit per cycle.
// ----------------------------------------------------------------------------
module lpht_urem #(
  parameter int DIV_W = 11
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [lpht_pkg::KEY_W-1:0] dividend,
  input  logic [DIV_W-1:0]         divisor,
  output logic                     done,
  output logic [DIV_W-1:0]         rem
);

  logic                          busy_r;
  logic                          done_r;
  logic [lpht_pkg::KEY_BITC-1:0] bit_cnt_r;
  logic [lpht_pkg::KEY_W-1:0]    dvd_r;
  logic [DIV_W-1:0]              dvs_r;
  logic [DIV_W-1:0]              rem_r;
  logic [DIV_W-1:0]              rem_nxt;
  logic [DIV_W:0]                trial;
  logic [DIV_W:0]                diff;
  logic                          last_bit;

  // Shift in the next dividend bit and subtract where it fits
  always_comb begin
    trial    = {rem_r, dvd_r[lpht_pkg::KEY_W-1]};
    diff     = trial - {1'b0, dvs_r};
    rem_nxt  = (trial >= {1'b0, dvs_r}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    last_bit = (bit_cnt_r == lpht_pkg::KEY_BITC'(lpht_pkg::KEY_W - 1));
  end

  // Control: run for one pass over the key bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      done_r    <= 1'b0;
      bit_cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r    <= 1'b1;
        bit_cnt_r <= '0;
      end else if (busy_r) begin
        bit_cnt_r <= bit_cnt_r + lpht_pkg::KEY_BITC'(1);
        if (last_bit) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[lpht_pkg::KEY_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### hw/rtl/linear_probe_hash_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open addressing hash table with linear probing, insert and search.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one word: in_op (0 insert,
//   1 search) and in_key. Output channel (out_valid / out_stall) returns one
//   word per input: found, slot, probe_count and table_full.
//   cfg_wr_en / cfg_wr_data write the table size; the user must write it
//   only while the block is idle, and the block itself has no check for it.
//   Size zero acts as one, values above TABLE_DEPTH act as TABLE_DEPTH.
// Operation:
//   The home slot comes from a bit-serial remainder unit. Each probe then
//   reads the registered RAM in ST_PROBE and compares in ST_CHECK; a word
//   visits from 1 to table size slots. One word is processed at a time, and
//   in_stall is high until its result is loaded into the output register.
// Reset:
//   After reset a clearing pass writes every RAM entry empty, with in_stall
//   high. Config writes are taken during the pass.
// Stall:
//   A result held by out_stall stays in the output register. A new word may
//   be accepted meanwhile; its result waits until the register is free.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top #(
  parameter int unsigned TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [lpht_pkg::KEY_W-1:0]   in_key,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_found,
  output logic [lpht_pkg::SLOT_W-1:0]  out_slot,
  output logic [lpht_pkg::COUNT_W-1:0] out_probe_count,
  output logic                         out_table_full,
  input  logic                         cfg_wr_en,
  input  logic [lpht_pkg::SIZE_W-1:0]  cfg_wr_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int RAM_W = lpht_pkg::KEY_W + 1;

  lpht_pkg::state_t state_r, state_nxt;

  logic [lpht_pkg::SIZE_W-1:0] size_r;
  logic [CNT_W-1:0]            m_eff;
  logic [CNT_W-1:0]            m_r;
  logic                        op_r;
  logic [lpht_pkg::KEY_W-1:0]  key_r;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [CNT_W-1:0]            visited_r, visited_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [IDX_W-1:0]            clr_r;
  logic                        res_found_r, res_found_nxt;
  logic [IDX_W-1:0]            res_slot_r, res_slot_nxt;
  logic                        res_full_r, res_full_nxt;

  logic                        out_valid_r;
  logic                        out_found_r;
  logic [lpht_pkg::SLOT_W-1:0]  out_slot_r;
  logic [lpht_pkg::COUNT_W-1:0] out_probe_count_r;
  logic                        out_table_full_r;

  logic                        accept;
  logic                        out_free;
  logic                        clr_last;

  logic                        urem_done;
  logic [CNT_W-1:0]            urem_rem;

  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [RAM_W-1:0]            ram_wdata;
  logic [RAM_W-1:0]            ram_rdata;

  logic                        slot_occ;
  logic                        slot_empty;
  logic                        slot_hit;
  logic                        last_probe;
  logic                        probe_stop;

  // Clamp the configured size to 1..TABLE_DEPTH
  always_comb begin
    if (size_r == '0) begin
      m_eff = CNT_W'(1);
    end else if (32'(size_r) > TABLE_DEPTH) begin
      m_eff = CNT_W'(TABLE_DEPTH);
    end else begin
      m_eff = CNT_W'(size_r);
    end
  end

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign clr_last = (clr_r == IDX_W'(TABLE_DEPTH - 1));

  // Probe evaluation on the word read from the table
  always_comb begin
    slot_occ   = ram_rdata[lpht_pkg::KEY_W];
    slot_empty = !slot_occ;
    slot_hit   = slot_occ && (op_r == lpht_pkg::OP_SEARCH) &&
                 (ram_rdata[lpht_pkg::KEY_W-1:0] == key_r);
    last_probe = ((visited_r + CNT_W'(1)) == m_r);
    probe_stop = slot_empty || slot_hit || last_probe;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpht_pkg::ST_CLEAR: begin
        if (clr_last) state_nxt = lpht_pkg::ST_IDLE;
      end
      lpht_pkg::ST_IDLE: begin
        if (accept) state_nxt = lpht_pkg::ST_HASH;
      end
      lpht_pkg::ST_HASH: begin
        if (urem_done) state_nxt = lpht_pkg::ST_PROBE;
      end
      lpht_pkg::ST_PROBE: begin
        state_nxt = lpht_pkg::ST_CHECK;
      end
      lpht_pkg::ST_CHECK: begin
        state_nxt = probe_stop ? lpht_pkg::ST_DONE : lpht_pkg::ST_PROBE;
      end
      lpht_pkg::ST_DONE: begin
        if (out_free) state_nxt = lpht_pkg::ST_IDLE;
      end
      default: state_nxt = lpht_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and table write port
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = {1'b1, key_r};
    case (state_r)
      lpht_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      lpht_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      lpht_pkg::ST_CHECK: begin
        ram_we = slot_empty && (op_r == lpht_pkg::OP_INSERT);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Probe datapath next values
  always_comb begin
    idx_nxt       = idx_r;
    visited_nxt   = visited_r;
    count_nxt     = count_r;
    res_found_nxt = res_found_r;
    res_slot_nxt  = res_slot_r;
    res_full_nxt  = res_full_r;
    case (state_r)
      lpht_pkg::ST_HASH: begin
        idx_nxt     = IDX_W'(urem_rem);
        visited_nxt = '0;
        count_nxt   = '0;
      end
      lpht_pkg::ST_CHECK: begin
        if (slot_occ && (op_r == lpht_pkg::OP_SEARCH)) begin
          count_nxt = count_r + CNT_W'(1);
        end
        res_found_nxt = (slot_empty && (op_r == lpht_pkg::OP_INSERT)) || slot_hit;
        res_slot_nxt  = res_found_nxt ? idx_r : '0;
        res_full_nxt  = !(slot_empty || slot_hit);
        visited_nxt   = visited_r + CNT_W'(1);
        if ((CNT_W'(idx_r) + CNT_W'(1)) == m_r) begin
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        idx_nxt = idx_r;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpht_pkg::ST_CLEAR;
      size_r      <= lpht_pkg::SIZE_RESET;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end
      if (state_r == lpht_pkg::ST_CLEAR) begin
        clr_r <= clr_r + IDX_W'(1);
      end
      if ((state_r == lpht_pkg::ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      key_r <= in_key;
      m_r   <= m_eff;
    end
    idx_r       <= idx_nxt;
    visited_r   <= visited_nxt;
    count_r     <= count_nxt;
    res_found_r <= res_found_nxt;
    res_slot_r  <= res_slot_nxt;
    res_full_r  <= res_full_nxt;
    if ((state_r == lpht_pkg::ST_DONE) && out_free) begin
      out_found_r       <= res_found_r;
      out_slot_r        <= lpht_pkg::SLOT_W'(res_slot_r);
      out_probe_count_r <= lpht_pkg::COUNT_W'(count_r);
      out_table_full_r  <= res_full_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_slot        = out_slot_r;
  assign out_probe_count = out_probe_count_r;
  assign out_table_full  = out_table_full_r;

  // Home slot: key modulo effective size
  lpht_urem #(
    .DIV_W (CNT_W)
  ) u_urem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (in_key),
    .divisor  (m_eff),
    .done     (urem_done),
    .rem      (urem_rem)
  );

  // Slot store: occupied bit over key
  lpht_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // A full table never reports a hit
  a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_table_full_r) |-> !out_found_r)
    else $error("table_full reported together with found");

  // Inserts make no key comparisons
  a_insert_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lpht_pkg::ST_DONE && op_r == lpht_pkg::OP_INSERT) |-> (count_r == '0))
    else $error("insert reported a nonzero probe count");

  // Probing stays inside the active slots
  a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lpht_pkg::ST_PROBE) |-> ((visited_r < m_r) && (CNT_W'(idx_r) < m_r)))
    else $error("probe beyond table size");

  // An item write lands only on a slot that read empty
  a_write_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lpht_pkg::ST_CHECK && ram_we) |-> !ram_rdata[lpht_pkg::KEY_W])
    else $error("insert overwrote an occupied slot");

endmodule
